### rtl/core/ptc_pkg.sv
// Shared types, constants and helpers for the pressure/temperature compensation block.
// Used by ptc_div and pressure_temp_compensation; no dependencies.
package ptc_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_TEMP_TRIM       = 2'd0;
    localparam logic [1:0] REG_PRESS_TRIM_LOW  = 2'd1;
    localparam logic [1:0] REG_PRESS_TRIM_HIGH = 2'd2;
    localparam logic [1:0] REG_PRESS_TRIM_LAST = 2'd3;

    localparam int DIV_BITS = 32;

    // Fields that ride alongside the divider
    typedef struct packed {
        logic [31:0] fine;
        logic [23:0] centi;
        logic        dbl;
        logic        ok;
    } div_side_t;

    // Sign-extend a 16-bit trim word to 32 bits
    function automatic logic [31:0] sext16(input logic [15:0] v);
        sext16 = {{16{v[15]}}, v};
    endfunction

    // Arithmetic right shift of a 32-bit word
    function automatic logic [31:0] sra32(input logic [31:0] v, input int unsigned n);
        sra32 = 32'($signed(v) >>> n);
    endfunction

    // One restoring division step over {remainder, dividend/quotient}
    function automatic logic [63:0] div_step(input logic [63:0] rq, input logic [31:0] d);
        logic [64:0] t;
        logic [32:0] hi;
        t  = {rq, 1'b0};
        hi = t[64:32];
        if (hi >= {1'b0, d}) begin
            hi   = hi - {1'b0, d};
            t[0] = 1'b1;
        end
        div_step = {hi[31:0], t[31:0]};
    endfunction

endpackage

### rtl/core/ptc_div.sv
// Pipelined unsigned 32/32 divider, one quotient bit per stage.
// Depends on ptc_pkg (div_step, div_side_t).
module ptc_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [31:0]         dividend,
    input  logic [31:0]         divisor,
    input  ptc_pkg::div_side_t  in_side,
    output logic                out_valid,
    output logic [31:0]         quotient,
    output ptc_pkg::div_side_t  out_side
);

    logic [63:0]        rq_reg   [ptc_pkg::DIV_BITS];
    logic [31:0]        d_reg    [ptc_pkg::DIV_BITS];
    ptc_pkg::div_side_t side_reg [ptc_pkg::DIV_BITS];
    logic [ptc_pkg::DIV_BITS-1:0] v_reg;

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[ptc_pkg::DIV_BITS-2:0], in_valid};
        end
    end

    // Advance remainder/quotient stages
    always_ff @(posedge aclk) begin
        if (en) begin
            rq_reg[0]   <= ptc_pkg::div_step({32'd0, dividend}, divisor);
            d_reg[0]    <= divisor;
            side_reg[0] <= in_side;
            for (int k = 1; k < ptc_pkg::DIV_BITS; k++) begin
                rq_reg[k]   <= ptc_pkg::div_step(rq_reg[k-1], d_reg[k-1]);
                d_reg[k]    <= d_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = v_reg[ptc_pkg::DIV_BITS-1];
    assign quotient  = rq_reg[ptc_pkg::DIV_BITS-1][31:0];
    assign out_side  = side_reg[ptc_pkg::DIV_BITS-1];

endmodule

### rtl/core/pressure_temp_compensation.sv
// Top level: 32-bit integer barometric temperature/pressure compensation.
// Depends on ptc_pkg and ptc_div.
//
//  channel | ports                 | contents
//  --------+-----------------------+------------------------------------------------
//  input   | s_tvalid/tready/tdata | raw temperature and raw pressure readings
//  result  | m_tvalid/tready/tdata | fine temp, centi temp, pressure Pa, valid flag
//  config  | cfg_we/addr/wdata     | trim words, write only
//
// One request per cycle while the result is not stalled; the pipeline has 11 arithmetic stages,
// 32 divider stages (one quotient bit each) and 3 correction stages.
// The whole pipeline advances together; when the result is stalled every stage holds.
// Reset clears all valid bits and trim registers.
module pressure_temp_compensation (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // fine_temperature[31:0], temperature_centi[55:32],
                                   // pressure_pa[87:56], pressure_valid[88], zero pad
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [63:0] cfg_wdata
);

    logic [47:0] temp_trim_reg;
    logic [63:0] press_lo_reg;
    logic [63:0] press_hi_reg;
    logic [15:0] press_last_reg;

    // Write trim registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_trim_reg  <= '0;
            press_lo_reg   <= '0;
            press_hi_reg   <= '0;
            press_last_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                ptc_pkg::REG_TEMP_TRIM:       temp_trim_reg  <= cfg_wdata[47:0];
                ptc_pkg::REG_PRESS_TRIM_LOW:  press_lo_reg   <= cfg_wdata;
                ptc_pkg::REG_PRESS_TRIM_HIGH: press_hi_reg   <= cfg_wdata;
                ptc_pkg::REG_PRESS_TRIM_LAST: press_last_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = {16'd0, temp_trim_reg[15:0]};
    assign t2 = ptc_pkg::sext16(temp_trim_reg[31:16]);
    assign t3 = ptc_pkg::sext16(temp_trim_reg[47:32]);
    assign p1 = {16'd0, press_lo_reg[15:0]};
    assign p2 = ptc_pkg::sext16(press_lo_reg[31:16]);
    assign p3 = ptc_pkg::sext16(press_lo_reg[47:32]);
    assign p4 = ptc_pkg::sext16(press_lo_reg[63:48]);
    assign p5 = ptc_pkg::sext16(press_hi_reg[15:0]);
    assign p6 = ptc_pkg::sext16(press_hi_reg[31:16]);
    assign p7 = ptc_pkg::sext16(press_hi_reg[47:32]);
    assign p8 = ptc_pkg::sext16(press_hi_reg[63:48]);
    assign p9 = ptc_pkg::sext16(press_last_reg);

    logic en;
    logic out_v_reg;
    assign en       = !out_v_reg || m_tready;
    assign s_tready = en;

    logic [19:0] rt, rp;
    assign rt = s_tdata[19:0];
    assign rp = s_tdata[39:20];

    // Stage valid bits before the divider
    logic [10:0] v_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[9:0], s_tvalid};
        end
    end

    logic [31:0] a1_reg, b1_reg;
    logic [19:0] rp_reg [9];
    logic [31:0] at2_reg, bb_reg;
    logic [31:0] ta3_reg, bt3_reg;
    logic [31:0] fine_reg [4:10];
    logic [23:0] centi_reg [5:10];
    logic [31:0] x5_reg, q5_reg;
    logic [31:0] sq6_reg, xp5_reg, p2x_reg;
    logic [31:0] y7_reg, p3s_reg, xp5b_reg, p2xb_reg;
    logic [31:0] y8_reg, x8_reg, y9_reg;
    logic [31:0] x9_reg;
    logic [31:0] div10_reg, pr10_reg;
    logic [31:0] dvd11_reg, dvs11_reg;
    ptc_pkg::div_side_t side11_reg;

    logic [31:0] fine4_next, x5_next, centi_tmp, y8_tmp, y8_next, x8_next, pr10_next;
    always_comb begin
        fine4_next = ptc_pkg::sra32(ta3_reg, 0) + ptc_pkg::sra32(bt3_reg, 14);
        x5_next    = ptc_pkg::sra32(fine_reg[4], 1) - 32'd64000;
        centi_tmp  = {fine_reg[4][29:0], 2'b00} + fine_reg[4] + 32'd128;
        y8_tmp     = y7_reg + {xp5b_reg[30:0], 1'b0};
        y8_next    = ptc_pkg::sra32(y8_tmp, 2) + {p4[15:0], 16'd0};
        x8_next    = ptc_pkg::sra32(ptc_pkg::sra32(p3s_reg, 3) + ptc_pkg::sra32(p2xb_reg, 1), 18);
        pr10_next  = 32'((32'd1048576 - {12'd0, rp_reg[8]} - ptc_pkg::sra32(y9_reg, 12))
                         * 32'd3125);
    end

    // Arithmetic stages ahead of the divider
    always_ff @(posedge aclk) begin
        if (en) begin
            // trim offsets
            a1_reg    <= {15'd0, rt[19:3]} - {t1[30:0], 1'b0};
            b1_reg    <= {16'd0, rt[19:4]} - t1;
            rp_reg[0] <= rp;
            for (int k = 1; k < 9; k++) rp_reg[k] <= rp_reg[k-1];
            // temperature products
            at2_reg   <= 32'(a1_reg * t2);
            bb_reg    <= 32'(b1_reg * b1_reg);
            ta3_reg   <= ptc_pkg::sra32(at2_reg, 11);
            bt3_reg   <= 32'(ptc_pkg::sra32(bb_reg, 12) * t3);
            fine_reg[4] <= fine4_next;
            // pressure setup
            x5_reg    <= x5_next;
            q5_reg    <= ptc_pkg::sra32(x5_next, 2);
            centi_reg[5] <= centi_tmp[31:8];
            for (int k = 5; k <= 10; k++) fine_reg[k] <= fine_reg[k-1];
            for (int k = 6; k <= 10; k++) centi_reg[k] <= centi_reg[k-1];
            sq6_reg   <= 32'(q5_reg * q5_reg);
            xp5_reg   <= 32'(x5_reg * p5);
            p2x_reg   <= 32'(p2 * x5_reg);
            y7_reg    <= 32'(ptc_pkg::sra32(sq6_reg, 11) * p6);
            p3s_reg   <= 32'(p3 * ptc_pkg::sra32(sq6_reg, 13));
            xp5b_reg  <= xp5_reg;
            p2xb_reg  <= p2x_reg;
            y8_reg    <= y8_next;
            x8_reg    <= x8_next;
            y9_reg    <= y8_reg;
            x9_reg    <= 32'((32'd32768 + x8_reg) * p1);
            div10_reg <= ptc_pkg::sra32(x9_reg, 15);
            pr10_reg  <= pr10_next;
            // pick the divide branch by the top bit
            dvs11_reg <= div10_reg;
            if (!pr10_reg[31]) begin
                dvd11_reg <= {pr10_reg[30:0], 1'b0};
            end else begin
                dvd11_reg <= pr10_reg;
            end
            side11_reg.dbl   <= pr10_reg[31];
            side11_reg.ok    <= (div10_reg != 32'd0);
            side11_reg.fine  <= fine_reg[10];
            side11_reg.centi <= centi_reg[10];
        end
    end

    logic               dq_v;
    logic [31:0]        dq;
    ptc_pkg::div_side_t dq_side;

    ptc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v_reg[10]),
        .dividend  (dvd11_reg),
        .divisor   (dvs11_reg),
        .in_side   (side11_reg),
        .out_valid (dq_v),
        .quotient  (dq),
        .out_side  (dq_side)
    );

    // Correction stages after the divide
    logic [1:0]  pv_reg;
    logic [31:0] pr_reg [2], mm_reg, c2p_reg, c1_reg, c2_reg;
    ptc_pkg::div_side_t ps_reg [2];
    logic [31:0] pr_q, pr_out_next;
    logic [31:0] out_pr_reg;
    ptc_pkg::div_side_t out_side_reg;

    always_comb begin
        pr_q = dq_side.dbl ? {dq[30:0], 1'b0} : dq;
        pr_out_next = pr_reg[1]
                    + ptc_pkg::sra32(c1_reg + c2_reg + p7, 4);
        if (!ps_reg[1].ok) pr_out_next = 32'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg    <= '0;
            out_v_reg <= 1'b0;
        end else if (en) begin
            pv_reg    <= {pv_reg[0], dq_v};
            out_v_reg <= pv_reg[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pr_reg[0]    <= pr_q;
            ps_reg[0]    <= dq_side;
            mm_reg       <= 32'({3'd0, pr_q[31:3]} * {3'd0, pr_q[31:3]});
            c2p_reg      <= 32'({2'd0, pr_q[31:2]} * p8);
            pr_reg[1]    <= pr_reg[0];
            ps_reg[1]    <= ps_reg[0];
            c1_reg       <= ptc_pkg::sra32(32'(p9 * {13'd0, mm_reg[31:13]}), 12);
            c2_reg       <= ptc_pkg::sra32(c2p_reg, 13);
            out_pr_reg   <= pr_out_next;
            out_side_reg <= ps_reg[1];
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {7'd0, out_side_reg.ok, out_pr_reg, out_side_reg.centi,
                       out_side_reg.fine};

endmodule

### rtl/core/ptc_checker.sv
// Port-level checks for pressure_temp_compensation, bound to the top level.
// Depends on nothing but the top-level ports.
module ptc_assert (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata
);

    logic [31:0] centi_calc;
    assign centi_calc = 32'($signed(m_tdata[31:0] * 32'd5 + 32'd128) >>> 8);

    // A stalled result holds its data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Input is taken exactly when the result slot can move
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow result slot");

    // Zero divisor gives zero pressure
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[88] |-> m_tdata[87:56] == 32'd0)
        else $error("invalid pressure not zero");

    // Centi temperature agrees with fine temperature
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[55:32] == centi_calc[23:0])
        else $error("centi temperature mismatch");

endmodule

bind pressure_temp_compensation ptc_assert u_ptc_assert (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### verif/ptc_checker.sv
// Result checker for the pressure/temperature compensation block.
// Watches the request and result channels, predicts each result from the trim words.
// Depends on ptc_pkg for the register indexes.
`timescale 1ns / 1ps

module ptc_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [95:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [63:0] cfg_wdata,
    output int          fail_count,
    output int          pending_count
);

    typedef struct packed {
        logic [31:0] fine;
        logic [23:0] centi;
        logic [31:0] press;
        logic        ok;
    } comp_result_t;

    logic [47:0] t_trim;
    logic [63:0] p_lo, p_hi;
    logic [15:0] p_last;
    comp_result_t expected_q[$];

    function automatic logic [31:0] asr(input logic [31:0] v, input int n);
        return $signed(v) >>> n;
    endfunction

    function automatic logic [31:0] sx(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // Compute the compensated reading for one raw pair
    function automatic comp_result_t compensate(input logic [19:0] rt, input logic [19:0] rp);
        comp_result_t r;
        logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] a, b, fine, x, q, sq, y, pr, m, c1, c2;
        t1 = {16'd0, t_trim[15:0]};
        t2 = sx(t_trim[31:16]);
        t3 = sx(t_trim[47:32]);
        p1 = {16'd0, p_lo[15:0]};
        p2 = sx(p_lo[31:16]);
        p3 = sx(p_lo[47:32]);
        p4 = sx(p_lo[63:48]);
        p5 = sx(p_hi[15:0]);
        p6 = sx(p_hi[31:16]);
        p7 = sx(p_hi[47:32]);
        p8 = sx(p_hi[63:48]);
        p9 = sx(p_last);
        a = {12'd0, rt} >> 3;
        a = a - (t1 << 1);
        b = ({12'd0, rt} >> 4) - t1;
        b = asr(b * b, 12);
        fine = asr(a * t2, 11) + asr(b * t3, 14);
        r.fine = fine;
        r.centi = 24'(asr(fine * 32'd5 + 32'd128, 8));
        x = asr(fine, 1) - 32'd64000;
        q = asr(x, 2);
        sq = q * q;
        y = asr(sq, 11) * p6;
        y = y + ((x * p5) << 1);
        y = asr(y, 2) + (p4 << 16);
        x = asr(asr(p3 * asr(sq, 13), 3) + asr(p2 * x, 1), 18);
        x = asr((32'd32768 + x) * p1, 15);
        r.ok = (x != 32'd0);
        if (x == 32'd0) begin
            pr = 32'd0;
        end else begin
            pr = ((32'd1048576 - {12'd0, rp}) - asr(y, 12)) * 32'd3125;
            if (!pr[31]) pr = (pr << 1) / x;
            else pr = (pr / x) * 32'd2;
            m = ((pr >> 3) * (pr >> 3)) >> 13;
            c1 = asr(p9 * m, 12);
            c2 = asr((pr >> 2) * p8, 13);
            pr = pr + asr(c1 + c2 + p7, 4);
        end
        r.press = pr;
        return r;
    endfunction

    assign pending_count = expected_q.size();

    always @(posedge aclk) begin
        comp_result_t got, want;
        if (!aresetn) begin
            t_trim <= '0;
            p_lo <= '0;
            p_hi <= '0;
            p_last <= '0;
            expected_q.delete();
            fail_count <= 0;
        end else begin
            // Track trim writes
            if (cfg_we) begin
                case (cfg_addr)
                    ptc_pkg::REG_TEMP_TRIM: t_trim <= cfg_wdata[47:0];
                    ptc_pkg::REG_PRESS_TRIM_LOW: p_lo <= cfg_wdata;
                    ptc_pkg::REG_PRESS_TRIM_HIGH: p_hi <= cfg_wdata;
                    ptc_pkg::REG_PRESS_TRIM_LAST: p_last <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
            // Predict on each accepted request
            if (s_tvalid && s_tready)
                expected_q.push_back(compensate(s_tdata[19:0], s_tdata[39:20]));
            // Compare each accepted result with the oldest prediction
            if (m_tvalid && m_tready) begin
                got.fine = m_tdata[31:0];
                got.centi = m_tdata[55:32];
                got.press = m_tdata[87:56];
                got.ok = m_tdata[88];
                if (expected_q.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got != want) begin
                        if (fail_count < 10)
                            $display("mismatch: fine %h/%h centi %h/%h press %h/%h ok %b/%b",
                                     want.fine, got.fine, want.centi, got.centi,
                                     want.press, got.press, want.ok, got.ok);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

### verif/tb_pressure_temp_compensation.sv
// Testbench top: drives raw readings and trim writes into the compensation block.
// Depends on ptc_pkg, the block and ptc_checker.
`timescale 1ns / 1ps

module tb_pressure_temp_compensation;

    localparam int LATENCY = 46;

    logic aclk = 0, aresetn = 0;
    logic s_tvalid = 0, s_tready, m_tvalid, m_tready = 0, cfg_we = 0;
    logic [39:0] s_tdata = '0;
    logic [95:0] m_tdata;
    logic [1:0] cfg_addr = '0;
    logic [63:0] cfg_wdata = '0;
    int fail_count, pending_count;
    bit calm = 0, hold_off = 0;

    always #2 aclk = ~aclk;

    pressure_temp_compensation dut (.*);
    ptc_checker chk (.*);

    // Write one trim register while the block is idle
    task automatic write_trim(input logic [1:0] idx, input logic [63:0] v);
        @(negedge aclk);
        cfg_we <= 1;
        cfg_addr <= idx;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 0;
    endtask

    // Offer one request, with an optional random gap first
    task automatic send_reading(input logic [19:0] rt, input logic [19:0] rp);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {rp, rt};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (pending_count != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    // Program either one fixed fill pattern or realistic-looking trims with random spread
    task automatic load_trims(input bit extreme, input logic [63:0] fill);
        if (extreme) begin
            write_trim(ptc_pkg::REG_TEMP_TRIM, fill);
            write_trim(ptc_pkg::REG_PRESS_TRIM_LOW, fill);
            write_trim(ptc_pkg::REG_PRESS_TRIM_HIGH, fill);
            write_trim(ptc_pkg::REG_PRESS_TRIM_LAST, fill);
        end else begin
            write_trim(ptc_pkg::REG_TEMP_TRIM, 64'({16'($urandom_range(0, 65535)),
                                                    16'($urandom_range(20000, 30000)),
                                                    16'($urandom_range(20000, 30000))}));
            write_trim(ptc_pkg::REG_PRESS_TRIM_LOW, {16'($urandom), 16'($urandom),
                                                     16'(-$urandom_range(8000, 12000)),
                                                     16'($urandom_range(30000, 40000))});
            write_trim(ptc_pkg::REG_PRESS_TRIM_HIGH, {$urandom, $urandom});
            write_trim(ptc_pkg::REG_PRESS_TRIM_LAST, 64'($urandom));
        end
    endtask

    // Receiver: random stalls, one long hold-off on request
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready <= 0;
                repeat (200) @(negedge aclk);
                hold_off = 0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_tready <= 0;
                repeat ($urandom_range(1, 14) - 1) @(negedge aclk);
            end else begin
                m_tready <= 1;
            end
        end
    end

    initial begin
        #4000000;
        $display("status: fail");
        $finish;
    end

    initial begin
        repeat (3) @(negedge aclk);
        aresetn <= 1;
        // Zero trims: every divisor is zero
        send_reading(20'h00000, 20'h00000);
        send_reading(20'hFFFFF, 20'hFFFFF);
        drain();
        load_trims(1, '1);
        send_reading(20'h00000, 20'hFFFFF);
        send_reading(20'hFFFFF, 20'h00000);
        send_reading(20'h55555, 20'hAAAAA);
        drain();
        load_trims(1, 64'h8000_7FFF_8000_7FFF);
        send_reading(20'hFFFFF, 20'hFFFFF);
        send_reading(20'h00000, 20'h00000);
        send_reading(20'hAAAAA, 20'h55555);
        drain();
        load_trims(0, '0);
        for (int i = 0; i < 10; i++)
            send_reading(20'($urandom), 20'($urandom));
        drain();
        // Random phases, each with fresh trims; long hold-off in the first
        for (int ph = 0; ph < 5; ph++) begin
            load_trims(ph == 4, {$urandom, $urandom});
            if (ph == 0) hold_off = 1;
            if (ph == 4) calm = 1;
            for (int i = 0; i < 200; i++)
                send_reading(20'($urandom_range(300000, 700000)) ^ 20'($urandom_range(0, 1) ?
                             $urandom : 0), 20'($urandom));
            drain();
        end
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
